@@ rtl/line_edit_buffer_with_cursor_defines.svh @@
// Assertion macros used by the line edit buffer datapath (leb_dp).
// Expects signals named clk and rst in the module that uses them.
`ifndef LINE_EDIT_BUFFER_WITH_CURSOR_DEFINES_SVH
`define LINE_EDIT_BUFFER_WITH_CURSOR_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define LEB_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LEB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/leb_pkg.sv @@
// Shared types and constants for the line edit buffer.
// No dependencies; compiled before every other RTL file.
package leb_pkg;

  localparam int LINE_DEPTH_DEFAULT = 32;

  localparam int ACT_W   = 3;
  localparam int CHAR_W  = 8;
  localparam int RIDX_W  = 5;
  localparam int COUNT_W = 6;

  localparam logic [COUNT_W-1:0] MAX_LENGTH_RESET = 6'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_LEFT      = 3'd0,
    ACT_RIGHT     = 3'd1,
    ACT_BACKSPACE = 3'd2,
    ACT_INSERT    = 3'd3,
    ACT_READ      = 3'd4
  } act_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic walk;
    logic commit;
    logic publish;
  } leb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_busy;
  } leb_stat_t;

endpackage

@@ rtl/leb_ifs.sv @@
// Valid/ready channel interfaces for the line edit buffer.
// Depends on leb_pkg for field widths.
interface leb_edit_if import leb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [CHAR_W-1:0] char_code;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, action, char_code, read_index, input ready);
  modport sink   (input valid, action, char_code, read_index, output ready);
endinterface

interface leb_result_if import leb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [COUNT_W-1:0] line_length;
  logic [COUNT_W-1:0] cursor_pos;
  logic [CHAR_W-1:0]  read_char;

  modport source (output valid, accepted, line_length, cursor_pos, read_char, input ready);
  modport sink   (input valid, accepted, line_length, cursor_pos, read_char, output ready);
endinterface

interface leb_cfg_if import leb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] max_length;

  modport source (output valid, max_length, input ready);
  modport sink   (input valid, max_length, output ready);
endinterface

@@ rtl/line_edit_buffer_with_cursor.sv @@
// Top level of the line edit buffer: controller plus datapath.
// Depends on leb_pkg, leb_ifs, leb_dp and leb_ctrl.
//
//   channel  role  carries
//   -------  ----  ------------------------------------------------
//   edit     sink  action, char_code, read_index (one edit item)
//   result   src   accepted, line_length, cursor_pos, read_char
//   cfg      sink  max_length (always ready)
//
// Cursor moves, reads and ignored actions pass through the decode and done
// states to the result register. Backspace and insert add a shift walk and a
// commit state between them, the walk moving up to LINE_DEPTH - 1 characters:
// the text store has one read and one write port, so the shift walk moves one
// character per cycle.
// The next item is accepted while the previous result still waits in the
// result register; a stalled result holds the controller before publishing.
// Reset (rst, synchronous) empties the line and sets max_length to 16; the
// text store itself is not cleared.
module line_edit_buffer_with_cursor import leb_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
  input logic          clk,
  input logic          rst,
  leb_edit_if.sink     edit,
  leb_result_if.source result,
  leb_cfg_if.sink      cfg
);

  leb_cmd_t  cmd;
  leb_stat_t stat;

  // Register writes are to happen only while idle (the block does not enforce it); never back-pressure them
  assign cfg.ready = 1'b1;

  leb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (edit.valid),
    .in_ready  (edit.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  leb_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid),
    .cfg_max_length (cfg.max_length),
    .action         (edit.action),
    .char_code      (edit.char_code),
    .read_index     (edit.read_index),
    .cmd            (cmd),
    .stat           (stat),
    .res_accepted   (result.accepted),
    .res_length     (result.line_length),
    .res_cursor     (result.cursor_pos),
    .res_char       (result.read_char)
  );

endmodule

@@ rtl/leb_dp.sv @@
// Datapath: text store, fill count, cursor, shift walker and result register.
// Depends on leb_pkg and the assertion macro header.
`include "line_edit_buffer_with_cursor_defines.svh"

module leb_dp import leb_pkg::*; #(
  parameter int LINE_DEPTH = LINE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_max_length,
  input  logic [ACT_W-1:0]   action,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [RIDX_W-1:0]  read_index,
  input  leb_cmd_t           cmd,
  output leb_stat_t          stat,
  output logic               res_accepted,
  output logic [COUNT_W-1:0] res_length,
  output logic [COUNT_W-1:0] res_cursor,
  output logic [CHAR_W-1:0]  res_char
);

  localparam int AW   = $clog2(LINE_DEPTH);
  localparam int CW   = $clog2(LINE_DEPTH + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [COUNT_W-1:0] max_length;
  act_t               act_q;
  logic [CHAR_W-1:0]  ch_q;
  logic [RIDX_W-1:0]  ridx_q;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      cursor;
  logic [CW-1:0]      ptr;
  logic               wr_pend;
  logic [AW-1:0]      wr_addr;
  logic               rd_hit;
  logic               acc;

  logic [CHAR_W-1:0]  mem [LINE_DEPTH];
  logic [CHAR_W-1:0]  rdata;

  logic               left_ok, right_ok, bs_ok, ins_ok, hit;
  logic               is_bs, is_ins, is_read, walk_more, acc_now;
  logic [AW-1:0]      src, dst;
  logic               mem_re, mem_we;
  logic [AW-1:0]      mem_ra, mem_wa;
  logic [CHAR_W-1:0]  mem_wd;

  // Decode of the held item against the current line state
  always_comb begin
    is_bs    = (act_q == ACT_BACKSPACE);
    is_ins   = (act_q == ACT_INSERT);
    is_read  = (act_q == ACT_READ);
    left_ok  = (cursor != '0);
    right_ok = (cursor < fill);
    bs_ok    = (cursor != '0) && (fill != '0);
    ins_ok   = (CMPW'(fill) < CMPW'(max_length)) && (CMPW'(fill) < CMPW'(LINE_DEPTH));
    hit      = (CMPW'(ridx_q) < CMPW'(fill)) && (CMPW'(ridx_q) < CMPW'(LINE_DEPTH));
    case (act_q)
      ACT_LEFT:      acc_now = left_ok;
      ACT_RIGHT:     acc_now = right_ok;
      ACT_BACKSPACE: acc_now = bs_ok;
      ACT_INSERT:    acc_now = ins_ok;
      ACT_READ:      acc_now = 1'b1;
      default:       acc_now = 1'b0;
    endcase
    // Backspace pulls entries down (ptr -> ptr-1), insert pushes up (ptr-1 -> ptr)
    walk_more = is_bs ? (ptr < fill) : (ptr > cursor);
    src       = is_bs ? AW'(ptr) : AW'(ptr - 1'b1);
    dst       = is_bs ? AW'(ptr - 1'b1) : AW'(ptr);
    stat.need_walk = (is_bs && bs_ok) || (is_ins && ins_ok);
    stat.walk_busy = walk_more || wr_pend;
  end

  // Text store port selection
  always_comb begin
    mem_re = (cmd.exec && is_read && hit) || (cmd.walk && walk_more);
    mem_ra = cmd.walk ? src : AW'(ridx_q);
    mem_we = (cmd.walk && wr_pend) || (cmd.commit && is_ins);
    mem_wa = cmd.commit ? AW'(cursor) : wr_addr;
    mem_wd = cmd.commit ? ch_q : rdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
      fill       <= '0;
      cursor     <= '0;
      wr_pend    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_length <= cfg_max_length;
      end
      wr_pend <= cmd.walk && walk_more;
      if (cmd.exec) begin
        if (act_q == ACT_LEFT && left_ok) begin
          cursor <= cursor - 1'b1;
        end else if (act_q == ACT_RIGHT && right_ok) begin
          cursor <= cursor + 1'b1;
        end
      end else if (cmd.commit) begin
        if (is_bs) begin
          cursor <= cursor - 1'b1;
          fill   <= fill - 1'b1;
        end else if (is_ins) begin
          cursor <= cursor + 1'b1;
          fill   <= fill + 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= act_t'(action);
      ch_q   <= char_code;
      ridx_q <= read_index;
    end
    if (cmd.exec) begin
      acc    <= acc_now;
      rd_hit <= is_read && hit;
      ptr    <= is_bs ? cursor : fill;
    end else if (cmd.walk && walk_more) begin
      ptr     <= is_bs ? ptr + 1'b1 : ptr - 1'b1;
      wr_addr <= dst;
    end
    if (cmd.publish) begin
      res_accepted <= acc;
      res_length   <= COUNT_W'(fill);
      res_cursor   <= COUNT_W'(cursor);
      res_char     <= rd_hit ? rdata : '0;
    end
  end

  `LEB_ASSERT_ALWAYS(a_cursor_in_line, cursor <= fill, "cursor beyond fill count")
  `LEB_ASSERT_ALWAYS(a_fill_in_depth, CMPW'(fill) <= CMPW'(LINE_DEPTH), "fill count beyond depth")
  `LEB_ASSERT_IMPLY(a_no_rw_clash, mem_we && mem_re, mem_wa != mem_ra, "walk read hits its write")
  `LEB_ASSERT_IMPLY(a_commit_drained, cmd.commit, !wr_pend, "commit with a shift write pending")

endmodule

@@ rtl/leb_ctrl.sv @@
// Controller: sequences one item through decode, shift walk, commit and result.
// Depends on leb_pkg for the command and status structs.
module leb_ctrl import leb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  leb_stat_t stat,
  output leb_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_WALK   = 5'b00100,
    S_COMMIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.need_walk ? S_WALK : S_DONE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (!stat.walk_busy) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.publish || (out_valid && !out_ready);
    end
  end

endmodule

@@ tb/sv/tb_line_edit_buffer_with_cursor.sv @@
// Self-checking testbench for line_edit_buffer_with_cursor: a directed table, then random
// edit phases under several max_length settings, all with random stalls on both channels.
// Depends on leb_pkg, the leb_ifs interfaces and the line_edit_buffer_with_cursor RTL.
module tb_line_edit_buffer_with_cursor import leb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int DEPTH = LINE_DEPTH_DEFAULT;
  // Longest walk is DEPTH - 1 moves plus the control states; round up.
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_IDLE = 17;

  // Action codes the block does not define; it must answer them with no change.
  localparam logic [ACT_W-1:0] ACT_BAD_LO  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_BAD_MID = 3'd6;
  localparam logic [ACT_W-1:0] ACT_BAD_HI  = 3'd7;

  // Marks a phase whose max_length is drawn at run time.
  localparam int LIMIT_DRAWN = -1;

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] line_length;
    logic [COUNT_W-1:0] cursor_pos;
    logic [CHAR_W-1:0]  read_char;
  } edit_result_t;

  // One row of the directed table. Where has_fixed is set, the typed result is
  // the expectation; otherwise the line predictor supplies it.
  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [CHAR_W-1:0]  ch;
    logic [RIDX_W-1:0]  idx;
    logic               has_fixed;
    edit_result_t       fixed_res;
  } edit_row_t;

  typedef struct {
    int limit;
    int ins_pct;
    int bs_pct;
    int count;
  } edit_phase_t;

  localparam int N_ROWS = 25;

  edit_row_t directed_rows [0:N_ROWS-1] = '{
    // Empty line right after reset: moves and backspace blocked, reads give 0.
    '{ACT_LEFT,      8'h00, 5'd0,  1'b1, '{1'b0, 6'd0, 6'd0, 8'h00}},
    '{ACT_RIGHT,     8'h00, 5'd0,  1'b1, '{1'b0, 6'd0, 6'd0, 8'h00}},
    '{ACT_BACKSPACE, 8'h00, 5'd0,  1'b1, '{1'b0, 6'd0, 6'd0, 8'h00}},
    '{ACT_READ,      8'h00, 5'd0,  1'b1, '{1'b1, 6'd0, 6'd0, 8'h00}},
    '{ACT_READ,      8'hFF, 5'd31, 1'b1, '{1'b1, 6'd0, 6'd0, 8'h00}},
    // Undefined actions change nothing.
    '{ACT_BAD_LO,    8'hFF, 5'd31, 1'b1, '{1'b0, 6'd0, 6'd0, 8'h00}},
    '{ACT_BAD_MID,   8'h55, 5'd10, 1'b1, '{1'b0, 6'd0, 6'd0, 8'h00}},
    '{ACT_BAD_HI,    8'hAA, 5'd21, 1'b1, '{1'b0, 6'd0, 6'd0, 8'h00}},
    // Build a short line with extreme characters, then insert in the middle.
    '{ACT_INSERT,    8'h00, 5'd0,  1'b0, '0},
    '{ACT_INSERT,    8'hFF, 5'd31, 1'b0, '0},
    '{ACT_INSERT,    8'hA5, 5'd0,  1'b0, '0},
    '{ACT_LEFT,      8'h00, 5'd0,  1'b0, '0},
    '{ACT_LEFT,      8'h00, 5'd0,  1'b0, '0},
    '{ACT_INSERT,    8'h5A, 5'd0,  1'b0, '0},
    '{ACT_READ,      8'h00, 5'd0,  1'b0, '0},
    '{ACT_READ,      8'h00, 5'd1,  1'b0, '0},
    '{ACT_READ,      8'h00, 5'd2,  1'b0, '0},
    '{ACT_READ,      8'h00, 5'd3,  1'b0, '0},
    '{ACT_READ,      8'h00, 5'd4,  1'b0, '0},
    // Walk to the end; the last move is blocked.
    '{ACT_RIGHT,     8'h00, 5'd0,  1'b0, '0},
    '{ACT_RIGHT,     8'h00, 5'd0,  1'b0, '0},
    '{ACT_RIGHT,     8'h00, 5'd0,  1'b0, '0},
    // Backspace at the end, then in the middle of the line.
    '{ACT_BACKSPACE, 8'h00, 5'd0,  1'b0, '0},
    '{ACT_LEFT,      8'h00, 5'd0,  1'b0, '0},
    '{ACT_BACKSPACE, 8'h00, 5'd0,  1'b0, '0}
  };

  // Random phases: each sets max_length, then mixes edits with its own weights.
  // Order matters: a full line at 32 is followed by a limit of 1 (below the fill),
  // and the limit of 0 phase drains the line with backspace.
  edit_phase_t edit_phases [0:7] = '{
    '{32,          60,  5, 160},
    '{1,           30,  5, 100},
    '{63,          40, 15, 150},
    '{0,           30, 30, 150},
    '{5,           40, 20, 150},
    '{20,          35, 20, 150},
    '{LIMIT_DRAWN, 35, 20, 150},
    '{33,          50, 10, 150}
  };

  logic clk = 1'b0;
  logic rst;

  leb_edit_if   edit_ch ();
  leb_result_if result_ch ();
  leb_cfg_if    cfg_ch ();

  line_edit_buffer_with_cursor dut (
    .clk    (clk),
    .rst    (rst),
    .edit   (edit_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: a private copy of the line, its fill, the cursor and the limit.
  logic [CHAR_W-1:0] line_chars [0:DEPTH-1];
  int line_fill;
  int caret;
  int line_limit;

  // Results the block still owes, oldest first.
  edit_result_t expected_results [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_burst = 0;
  int take_burst = 0;

  // Apply one edit to the private line and return the result the block must give.
  function automatic edit_result_t apply_edit(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                                              logic [RIDX_W-1:0] idx);
    edit_result_t r;
    int lim;
    int i;
    r = '0;
    lim = (line_limit > DEPTH) ? DEPTH : line_limit;
    case (act)
      ACT_LEFT: begin
        if (caret != 0) begin
          caret--;
          r.accepted = 1'b1;
        end
      end
      ACT_RIGHT: begin
        if (caret < line_fill) begin
          caret++;
          r.accepted = 1'b1;
        end
      end
      ACT_BACKSPACE: begin
        if (caret != 0 && line_fill != 0) begin
          // Pull the tail down over the character before the cursor.
          for (i = caret; i < line_fill; i++) line_chars[i-1] = line_chars[i];
          caret--;
          line_fill--;
          r.accepted = 1'b1;
        end
      end
      ACT_INSERT: begin
        if (line_fill < lim) begin
          // Push the tail up to open a slot at the cursor.
          for (i = line_fill; i > caret; i--) line_chars[i] = line_chars[i-1];
          line_chars[caret] = ch;
          caret++;
          line_fill++;
          r.accepted = 1'b1;
        end
      end
      ACT_READ: begin
        r.accepted = 1'b1;
        if (int'(idx) < line_fill) r.read_char = line_chars[idx];
      end
      default: ;
    endcase
    r.line_length = COUNT_W'(line_fill);
    r.cursor_pos = COUNT_W'(caret);
    return r;
  endfunction

  // Draw an idle count: mostly short, sometimes up to the full range, and now and
  // then a run of back-to-back items with no idling at all.
  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 2);
    return $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endfunction

  // Offer one edit item, hold it until taken, then record what it must produce.
  // Valid drops only ahead of an idle gap, so back-to-back items keep it high.
  task automatic send_edit(logic [ACT_W-1:0] act, logic [CHAR_W-1:0] ch,
                           logic [RIDX_W-1:0] idx, logic has_fixed, edit_result_t fixed_res);
    int gap;
    edit_result_t predicted;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      edit_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edit_ch.valid      <= 1'b1;
    edit_ch.action     <= act;
    edit_ch.char_code  <= ch;
    edit_ch.read_index <= idx;
    do @(posedge clk); while (edit_ch.ready !== 1'b1);
    predicted = apply_edit(act, ch, idx);
    expected_results.push_back(has_fixed ? fixed_res : predicted);
  endtask

  // Drop valid and wait until every owed result is in, then let the block settle.
  task automatic drain_edits();
    edit_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write max_length while the block is idle and track it in the predictor.
  task automatic write_limit(int value);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.max_length <= COUNT_W'(value);
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    line_limit = value;
  endtask

  // Draw one random edit with the phase's weights; a few undefined codes mixed in.
  task automatic send_random_edit(int ins_pct, int bs_pct);
    int roll;
    logic [ACT_W-1:0] act;
    logic [RIDX_W-1:0] idx;
    roll = $urandom_range(0, 99);
    if (roll < 3) act = ACT_W'($urandom_range(ACT_BAD_LO, ACT_BAD_HI));
    else if (roll < 3 + ins_pct) act = ACT_INSERT;
    else if (roll < 3 + ins_pct + bs_pct) act = ACT_BACKSPACE;
    else begin
      case ($urandom_range(0, 2))
        0: act = ACT_LEFT;
        1: act = ACT_RIGHT;
        default: act = ACT_READ;
      endcase
    end
    // Aim half of the reads inside the line so they return real characters.
    if (line_fill > 0 && $urandom_range(0, 1) == 0) begin
      idx = RIDX_W'($urandom_range(0, line_fill - 1));
    end else begin
      idx = RIDX_W'($urandom_range(0, DEPTH - 1));
    end
    send_edit(act, CHAR_W'($urandom_range(0, 255)), idx, 1'b0, '0);
  endtask

  // Result side: stall at random, take each result and check it against the
  // oldest expectation, field by field.
  initial begin
    edit_result_t want;
    edit_result_t got;
    int stall;
    result_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = draw_gap(take_burst);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
      got = '{result_ch.accepted, result_ch.line_length, result_ch.cursor_pos,
              result_ch.read_char};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("accepted", int'(want.accepted), int'(got.accepted));
        check_field("line_length", int'(want.line_length), int'(got.line_length));
        check_field("cursor_pos", int'(want.cursor_pos), int'(got.cursor_pos));
        check_field("read_char", int'(want.read_char), int'(got.read_char));
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus: reset, directed table at the reset limit, then the random phases.
  initial begin
    int limit;
    rst = 1'b1;
    edit_ch.valid = 1'b0;
    edit_ch.action = ACT_LEFT;
    edit_ch.char_code = '0;
    edit_ch.read_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_length = '0;
    line_fill = 0;
    caret = 0;
    line_limit = int'(MAX_LENGTH_RESET);
    for (int i = 0; i < DEPTH; i++) line_chars[i] = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      send_edit(directed_rows[r].act, directed_rows[r].ch, directed_rows[r].idx,
                directed_rows[r].has_fixed, directed_rows[r].fixed_res);

    foreach (edit_phases[p]) begin
      drain_edits();
      limit = (edit_phases[p].limit == LIMIT_DRAWN) ? $urandom_range(0, 63)
                                                    : edit_phases[p].limit;
      write_limit(limit);
      repeat (edit_phases[p].count)
        send_random_edit(edit_phases[p].ins_pct, edit_phases[p].bs_pct);
    end

    // Wait out every owed result plus the longest walk, then report.
    drain_edits();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/leb_pkg.sv
rtl/leb_ifs.sv
rtl/leb_dp.sv
rtl/leb_ctrl.sv
rtl/line_edit_buffer_with_cursor.sv
tb/sv/tb_line_edit_buffer_with_cursor.sv
